FILE: sv/scp_pkg.sv
// Package for the sine/cosine polynomial block.
// Holds fixed widths, Q32/Q30 constants and the rounded Q30 multiply.
// No dependencies.
`timescale 1ns / 1ps

package scp_pkg;

  localparam int IN_W       = 24;
  localparam int OUT_W      = 18;
  localparam int RW         = 36;  // signed Q32 remainder
  localparam int XW         = 32;  // Q30 polynomial datapath
  localparam int LANES      = 2;
  localparam int SIN_LANE   = 0;
  localparam int NUM_STAGES = 11;
  localparam int Q_SH       = 30;

  localparam int DEF_ANGLE_FRAC_BITS = 16;
  localparam int DEF_OUT_FRAC_BITS   = 16;

  localparam logic [31:0]     TWO_OVER_PI_Q32 = 32'd2734261102;
  localparam logic [7:0]      PI2_HI_INT      = 8'd201;
  localparam int              PI2_HI_SH       = 25;
  localparam logic [20:0]     PI2_LO_Q32      = 21'd2078020;
  localparam logic [RW-1:0]   HALF_PI_Q32     = 36'd6746518852;

  localparam logic [30:0]     ONE_Q30 = 31'd1073741824;
  localparam logic [27:0]     C3_Q30  = 28'd178949812;
  localparam logic [23:0]     C5_Q30  = 24'd8927412;
  localparam logic [17:0]     C7_Q30  = 18'd199093;

  localparam logic [2*XW-1:0] Q30_RND = 64'h0000_0000_2000_0000;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // Unsigned Q30 product, rounded half up.
  function automatic logic [XW-1:0] mul_rnd(input logic [XW-1:0] a, input logic [XW-1:0] b);
    logic [2*XW-1:0] p;
    p = (2*XW)'(a) * (2*XW)'(b) + Q30_RND;
    return XW'(p >> Q_SH);
  endfunction

endpackage

FILE: sv/sincos_polynomial.sv
// Pipelined sine and cosine of a fixed-point angle.
// Quadrant reduction followed by an odd degree-7 polynomial per output.
// Depends on scp_pkg.
`timescale 1ns / 1ps

// Accepts one angle transaction every clock while angle_stall is low, and
// returns sine and cosine of it together. The pipeline depth is set by the
// reduction multiplies (angle times 2/pi, quarter-turn count times pi/2) followed
// by the five dependent Q30 multiplies of the Horner evaluation, each in a
// register stage of its own. A stall on the result side holds only as many
// stages as it must; bubbles are squeezed out. Outputs are Q(OUT_FRAC_BITS),
// rounded ties away from zero and saturated to +-1.0.
module sincos_polynomial
  import scp_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
  parameter int OUT_FRAC_BITS   = DEF_OUT_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    angle_valid,
  output logic                    angle_stall,
  input  logic signed [IN_W-1:0]  angle,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [OUT_W-1:0] sine,
  output logic signed [OUT_W-1:0] cosine
);

  localparam int QW  = (ANGLE_FRAC_BITS < IN_W - 2) ? IN_W - ANGLE_FRAC_BITS : 2;
  localparam int QSH = 32 + ANGLE_FRAC_BITS;
  localparam int MSH = 32 - ANGLE_FRAC_BITS;
  localparam int PW  = IN_W + 32;
  localparam int LW  = QW + 21;
  localparam int OSH = Q_SH - OUT_FRAC_BITS;
  localparam logic [XW-1:0] OUT_RND = XW'(1) << (OSH - 1);
  localparam logic [XW-1:0] OUT_SAT = XW'(1) << OUT_FRAC_BITS;

  // flow control
  logic [NUM_STAGES:1]   vld;
  logic [NUM_STAGES:1]   vin;
  logic [NUM_STAGES+1:1] adv;

  always_comb begin
    adv[NUM_STAGES+1] = !result_stall;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign vin          = {vld[NUM_STAGES-1:1], angle_valid};
  assign angle_stall  = !adv[1];
  assign result_valid = vld[NUM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  // stage 1: magnitude
  logic [IN_W-1:0] s1_mag;
  logic            s1_neg;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_neg <= angle[IN_W-1];
      s1_mag <= angle[IN_W-1] ? IN_W'(-angle) : IN_W'(angle);
    end
  end

  // stage 2: quarter-turn count
  logic [PW-1:0]   qprod;
  logic [QW-1:0]   s2_q;
  logic [IN_W-1:0] s2_mag;
  logic            s2_neg;

  assign qprod = PW'(s1_mag) * PW'(TWO_OVER_PI_Q32);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_q   <= QW'(qprod >> QSH);
      s2_mag <= s1_mag;
      s2_neg <= s1_neg;
    end
  end

  // stage 3: count times pi/2 in two parts
  logic [LW-1:0] qlo_prod;
  logic [RW-1:0] s3_m;
  logic [RW-1:0] s3_qhi;
  logic [RW-1:0] s3_qlo;
  logic [1:0]    s3_quad;
  logic          s3_neg;

  assign qlo_prod = LW'(s2_q) * LW'(PI2_LO_Q32);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_m    <= RW'(s2_mag) << MSH;
      s3_qhi  <= RW'(RW'(s2_q) * RW'(PI2_HI_INT)) << PI2_HI_SH;
      s3_qlo  <= RW'(qlo_prod);
      s3_quad <= s2_q[1:0];
      s3_neg  <= s2_neg;
    end
  end

  // stage 4: remainder and per-output argument
  logic signed [RW-1:0] r_val;
  logic signed [RW-1:0] rm_val;
  logic signed [RW-1:0] arg_next [LANES];
  logic signed [RW-1:0] s4_arg   [LANES];
  logic                 s4_neg;

  always_comb begin
    r_val  = s3_m - s3_qhi - s3_qlo;
    rm_val = r_val - HALF_PI_Q32;
    case (s3_quad)
      QUAD_0: begin
        arg_next[0] = r_val;
        arg_next[1] = -rm_val;
      end
      QUAD_1: begin
        arg_next[0] = -rm_val;
        arg_next[1] = -r_val;
      end
      QUAD_2: begin
        arg_next[0] = -r_val;
        arg_next[1] = rm_val;
      end
      default: begin
        arg_next[0] = rm_val;
        arg_next[1] = r_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int l = 0; l < LANES; l++) begin
        s4_arg[l] <= arg_next[l];
      end
      s4_neg <= s3_neg;
    end
  end

  // stage 5: |arg| to Q30
  logic [RW-1:0] amag   [LANES];
  logic [XW-1:0] x_next [LANES];
  logic [XW-1:0] s5_x   [LANES];
  logic          s5_nres[LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      amag[l]   = s4_arg[l][RW-1] ? RW'(-s4_arg[l]) : RW'(s4_arg[l]);
      x_next[l] = XW'((amag[l] + RW'(2)) >> 2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int l = 0; l < LANES; l++) begin
        s5_x[l]    <= x_next[l];
        s5_nres[l] <= (l == SIN_LANE) ? (s4_arg[l][RW-1] ^ s4_neg) : s4_arg[l][RW-1];
      end
    end
  end

  // stage 6: x^2
  logic [XW-1:0] s6_x   [LANES];
  logic [XW-1:0] s6_x2  [LANES];
  logic          s6_nres[LANES];

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int l = 0; l < LANES; l++) begin
        s6_x2[l]   <= mul_rnd(s5_x[l], s5_x[l]);
        s6_x[l]    <= s5_x[l];
        s6_nres[l] <= s5_nres[l];
      end
    end
  end

  // stage 7: t1 = c5 - x2*c7
  logic [XW-1:0] s7_x   [LANES];
  logic [XW-1:0] s7_x2  [LANES];
  logic [23:0]   s7_t1  [LANES];
  logic          s7_nres[LANES];

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      for (int l = 0; l < LANES; l++) begin
        s7_t1[l]   <= C5_Q30 - 24'(mul_rnd(s6_x2[l], XW'(C7_Q30)));
        s7_x2[l]   <= s6_x2[l];
        s7_x[l]    <= s6_x[l];
        s7_nres[l] <= s6_nres[l];
      end
    end
  end

  // stage 8: |t2| = c3 - x2*t1
  logic [XW-1:0] s8_x   [LANES];
  logic [XW-1:0] s8_x2  [LANES];
  logic [27:0]   s8_t2m [LANES];
  logic          s8_nres[LANES];

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      for (int l = 0; l < LANES; l++) begin
        s8_t2m[l]  <= C3_Q30 - 28'(mul_rnd(s7_x2[l], XW'(s7_t1[l])));
        s8_x2[l]   <= s7_x2[l];
        s8_x[l]    <= s7_x[l];
        s8_nres[l] <= s7_nres[l];
      end
    end
  end

  // stage 9: t3 = 1 - x2*|t2|
  logic [XW-1:0] s9_x   [LANES];
  logic [30:0]   s9_t3  [LANES];
  logic          s9_nres[LANES];

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      for (int l = 0; l < LANES; l++) begin
        s9_t3[l]   <= ONE_Q30 - 31'(mul_rnd(s8_x2[l], XW'(s8_t2m[l])));
        s9_x[l]    <= s8_x[l];
        s9_nres[l] <= s8_nres[l];
      end
    end
  end

  // stage 10: y = x*t3
  logic [XW-1:0] s10_y   [LANES];
  logic          s10_nres[LANES];

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      for (int l = 0; l < LANES; l++) begin
        s10_y[l]    <= mul_rnd(s9_x[l], XW'(s9_t3[l]));
        s10_nres[l] <= s9_nres[l];
      end
    end
  end

  // stage 11: round, saturate, sign
  logic [XW-1:0] ou   [LANES];
  logic [XW-1:0] osat [LANES];
  logic [XW-1:0] oval [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ou[l]   = (s10_y[l] + OUT_RND) >> OSH;
      osat[l] = (ou[l] > OUT_SAT) ? OUT_SAT : ou[l];
      oval[l] = s10_nres[l] ? XW'(-osat[l]) : osat[l];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[11]) begin
      sine   <= oval[0][OUT_W-1:0];
      cosine <= oval[1][OUT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    angle_stall |-> (&vld))
    else $error("input stalled with a free stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (angle_valid && !angle_stall) |=> vld[1])
    else $error("accepted transaction did not enter stage 1");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0))
    else $error("pipeline not empty after reset");

  a_t2_no_wrap: assert property (@(posedge clk) disable iff (rst)
    vld[8] |-> ((s8_t2m[0] <= C3_Q30) && (s8_t2m[1] <= C3_Q30)))
    else $error("Horner term wrapped");
`endif

endmodule
